FILE: rtl/core/trcc_pkg.sv
// ----------------------------------------------------------------------------
// trcc_pkg: shared types and constants for the record checksum checker
// Status codes, the per-byte result record and the rotate-add checksum step.
// ----------------------------------------------------------------------------
package trcc_pkg;

    // Verdict codes reported with record_done
    localparam logic [2:0] ST_IN_PROGRESS  = 3'd0;
    localparam logic [2:0] ST_ACCEPTED     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
    localparam logic [2:0] ST_BAD_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_LEN_RANGE    = 3'd4;

    // Magic value after reset: "Args"
    localparam logic [31:0] MAGIC_RESET = 32'h4172_6773;

    // One result per input byte
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        record_done;
        logic [2:0]  status;
        logic [11:0] payload_length;
    } trcc_result_t;

    // Rotate left by one, then add the byte sign-extended, mod 2^16
    function automatic logic [15:0] csum_add(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] rot;
        logic [15:0] ext;
        rot = {c[14:0], c[15]};
        ext = {{8{b[7]}}, b};
        return rot + ext;
    endfunction

endpackage

FILE: rtl/core/trcc_stream_if.sv
// ----------------------------------------------------------------------------
// trcc_stream_if: valid/ready channels of the record checksum checker
// Byte input channel and per-byte result channel.
// ----------------------------------------------------------------------------
interface trcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_record;

    modport source (output valid, output data_byte, output start_record, input ready);
    modport sink   (input valid, input data_byte, input start_record, output ready);
endinterface

interface trcc_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        record_done;
    logic [2:0]  status;
    logic [11:0] payload_length;

    modport source (output valid, output payload_byte, output payload_valid,
                    output record_done, output status, output payload_length,
                    input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input record_done, input status, input payload_length,
                    output ready);
endinterface

FILE: rtl/core/trcc_parser.sv
// ----------------------------------------------------------------------------
// trcc_parser: record framing state and checksum datapath
// Holds the record state, advances it by one byte per step and forms the
// result for that byte.
// ----------------------------------------------------------------------------
module trcc_parser #(
    parameter int MAX_LEN = 4095
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step_en,
    input  logic [7:0]                data_byte,
    input  logic                      start_record,
    input  logic [31:0]               magic_word,
    output trcc_pkg::trcc_result_t    res_next
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    logic [1:0]       phase_reg,  phase_next;
    logic [2:0]       hidx_reg,   hidx_next;
    logic [15:0]      stored_reg, stored_next;
    logic [LEN_W-1:0] rlen_reg,   rlen_next;
    logic [LEN_W-1:0] rem_reg,    rem_next;
    logic [15:0]      run_reg,    run_next;
    logic [7:0]       lenlo_reg,  lenlo_next;

    logic [7:0]       want_byte;
    logic [15:0]      full_len;
    logic [15:0]      csum_step;
    logic [LEN_W-1:0] rem_dec;
    logic [15:0]      len_ext;

    // Expected tag byte for the current header position
    always_comb
    begin
        case (start_record ? 2'd0 : hidx_reg[1:0])
            2'd0:    want_byte = magic_word[31:24];
            2'd1:    want_byte = magic_word[23:16];
            2'd2:    want_byte = magic_word[15:8];
            default: want_byte = magic_word[7:0];
        endcase
    end

    // Next state and result for this byte
    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        stored_next = stored_reg;
        rlen_next   = rlen_reg;
        rem_next    = rem_reg;
        run_next    = run_reg;
        lenlo_next  = lenlo_reg;

        res_next.payload_byte  = 8'd0;
        res_next.payload_valid = 1'b0;
        res_next.record_done   = 1'b0;
        res_next.status        = trcc_pkg::ST_IN_PROGRESS;

        // start mark abandons any record in flight
        if (start_record)
        begin
            phase_next  = PH_HEADER;
            hidx_next   = 3'd0;
            stored_next = 16'd0;
            rlen_next   = '0;
            rem_next    = '0;
            run_next    = 16'd0;
            lenlo_next  = 8'd0;
        end

        full_len  = {data_byte, lenlo_next};
        csum_step = trcc_pkg::csum_add(run_next, data_byte);
        rem_dec   = (rem_next != '0) ? rem_next - 1'b1 : rem_next;

        unique case (phase_next)
            PH_HEADER:
            begin
                case (hidx_next)
                    3'd0, 3'd1, 3'd2, 3'd3:
                    begin
                        if (data_byte != want_byte)
                        begin
                            res_next.record_done = 1'b1;
                            res_next.status      = trcc_pkg::ST_BAD_MAGIC;
                            phase_next           = PH_IDLE;
                        end
                        else
                        begin
                            hidx_next = hidx_next + 3'd1;
                        end
                    end
                    3'd4:
                    begin
                        stored_next[7:0] = data_byte;
                        hidx_next        = 3'd5;
                    end
                    3'd5:
                    begin
                        stored_next[15:8] = data_byte;
                        hidx_next         = 3'd6;
                    end
                    3'd6:
                    begin
                        run_next   = csum_step;
                        lenlo_next = data_byte;
                        hidx_next  = 3'd7;
                    end
                    default:
                    begin
                        run_next  = csum_step;
                        hidx_next = 3'd0;
                        if (full_len[15] || (full_len > 16'(MAX_LEN)))
                        begin
                            rlen_next            = '0;
                            res_next.record_done = 1'b1;
                            res_next.status      = trcc_pkg::ST_LEN_RANGE;
                            phase_next           = PH_IDLE;
                        end
                        else if (full_len == 16'd0)
                        begin
                            rlen_next            = '0;
                            res_next.record_done = 1'b1;
                            res_next.status      = (csum_step == stored_next) ?
                                                   trcc_pkg::ST_ACCEPTED :
                                                   trcc_pkg::ST_BAD_CHECKSUM;
                            phase_next           = PH_IDLE;
                        end
                        else
                        begin
                            rlen_next  = full_len[LEN_W-1:0];
                            rem_next   = full_len[LEN_W-1:0];
                            phase_next = PH_PAYLOAD;
                        end
                    end
                endcase
            end
            PH_PAYLOAD:
            begin
                res_next.payload_byte  = data_byte;
                res_next.payload_valid = 1'b1;
                run_next               = csum_step;
                rem_next               = rem_dec;
                if (rem_dec == '0)
                begin
                    res_next.record_done = 1'b1;
                    res_next.status      = (csum_step == stored_next) ?
                                           trcc_pkg::ST_ACCEPTED :
                                           trcc_pkg::ST_BAD_CHECKSUM;
                    phase_next           = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        len_ext                 = 16'(rlen_next);
        res_next.payload_length = len_ext[11:0];
    end

    // Record state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            hidx_reg   <= 3'd0;
            stored_reg <= 16'd0;
            rlen_reg   <= '0;
            rem_reg    <= '0;
            run_reg    <= 16'd0;
            lenlo_reg  <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            stored_reg <= stored_next;
            rlen_reg   <= rlen_next;
            rem_reg    <= rem_next;
            run_reg    <= run_next;
            lenlo_reg  <= lenlo_next;
        end
    end

endmodule

FILE: rtl/core/tagged_record_checksum_checker.sv
// ----------------------------------------------------------------------------
// Output: a result is in the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle; a byte is taken while the held result is
//   being taken in the same cycle, so only a stalled result channel slows it.
// Reset: record state idle, counters and checksums zero, magic "Args",
//   output register empty.
// ----------------------------------------------------------------------------
// tagged_record_checksum_checker: record framing and checksum verdict
// Parses magic, stored checksum and length, passes payload bytes through and
// reports the record verdict, one result per input byte.
// ----------------------------------------------------------------------------
module tagged_record_checksum_checker #(
    parameter int MAX_LEN = 4095
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [31:0]           wr_data,
    trcc_byte_if.sink             stream,
    trcc_result_if.source         result
);

    logic [31:0]            magic_word_reg;
    logic                   out_valid_reg;
    trcc_pkg::trcc_result_t res_reg;
    trcc_pkg::trcc_result_t res_next;
    logic                   take;

    // Byte is taken when the output register is free or drains this cycle
    assign stream.ready = !out_valid_reg || result.ready;
    assign take         = stream.valid && stream.ready;

    // Magic tag register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg <= trcc_pkg::MAGIC_RESET;
        end
        else if (wr_en)
        begin
            magic_word_reg <= wr_data;
        end
    end

    trcc_parser #(
        .MAX_LEN (MAX_LEN)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (take),
        .data_byte    (stream.data_byte),
        .start_record (stream.start_record),
        .magic_word   (magic_word_reg),
        .res_next     (res_next)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.payload_byte   = res_reg.payload_byte;
    assign result.payload_valid  = res_reg.payload_valid;
    assign result.record_done    = res_reg.record_done;
    assign result.status         = res_reg.status;
    assign result.payload_length = res_reg.payload_length;

    // Verdict code present exactly when the record is done
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.record_done == (result.status != trcc_pkg::ST_IN_PROGRESS)))
        else $error("record_done and status disagree");

    // Payload bytes never end a record on a header verdict
    a_payload_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.payload_valid) |->
            (result.status != trcc_pkg::ST_BAD_MAGIC &&
             result.status != trcc_pkg::ST_LEN_RANGE))
        else $error("payload byte carries a header verdict");

    // Every taken byte yields a result in the next cycle
    a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.ready) |=> result.valid)
        else $error("taken byte produced no result");

endmodule
